// ===== design/shp_pkg.sv =====
// shared types, character codes and the hex digit decoder of the strict hex parser
// no dependencies; compiled first
`timescale 1ns / 1ps

package shp_pkg;

  localparam int unsigned CharWidth  = 8;
  localparam int unsigned ValueOutW  = 64;
  localparam int unsigned NibbleW    = 4;

  localparam logic [CharWidth-1:0] CH_0    = 8'h30;
  localparam logic [CharWidth-1:0] CH_9    = 8'h39;
  localparam logic [CharWidth-1:0] CH_A_LO = 8'h61;
  localparam logic [CharWidth-1:0] CH_F_LO = 8'h66;
  localparam logic [CharWidth-1:0] CH_A_UP = 8'h41;
  localparam logic [CharWidth-1:0] CH_F_UP = 8'h46;
  localparam logic [CharWidth-1:0] CH_X_LO = 8'h78;
  localparam logic [CharWidth-1:0] CH_X_UP = 8'h58;
  localparam logic [CharWidth-1:0] HEX_TEN = 8'd10;

  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_LATER  = 2'd2;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_DIGITS = 2'd1,
    ST_BAD_CHAR  = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_e;

  typedef struct packed {
    logic [CharWidth-1:0] char_code;
    logic                 has_char;
    logic                 last;
  } item_t;

  typedef struct packed {
    logic [ValueOutW-1:0] value;
    status_e              status;
  } result_t;

  typedef struct packed {
    logic                 bad;
    logic [NibbleW-1:0]   nibble;
  } hex_digit_t;

  // digits and either case of a-f accepted, anything else flagged bad
  function automatic hex_digit_t hex_digit(input logic [CharWidth-1:0] c);
    hex_digit_t d;
    d.bad    = 1'b0;
    d.nibble = '0;
    if (c >= CH_0 && c <= CH_9) begin
      d.nibble = NibbleW'(c - CH_0);
    end else if (c >= CH_A_LO && c <= CH_F_LO) begin
      d.nibble = NibbleW'(c - CH_A_LO + HEX_TEN);
    end else if (c >= CH_A_UP && c <= CH_F_UP) begin
      d.nibble = NibbleW'(c - CH_A_UP + HEX_TEN);
    end else begin
      d.bad = 1'b1;
    end
    return d;
  endfunction

endpackage

// ===== design/shp_if.sv =====
// valid/ready channel interfaces for the character items and the result items
// depends on shp_pkg for the field widths
`timescale 1ns / 1ps

interface shp_in_if;
  logic                             valid;
  logic                             ready;
  logic [shp_pkg::CharWidth-1:0]    char_code;
  logic                             has_char;
  logic                             last;

  modport source (output valid, char_code, has_char, last, input ready);
  modport sink   (input valid, char_code, has_char, last, output ready);
endinterface

interface shp_out_if;
  logic                             valid;
  logic                             ready;
  logic [shp_pkg::ValueOutW-1:0]    value;
  logic [1:0]                       status;

  modport source (output valid, value, status, input ready);
  modport sink   (input valid, value, status, output ready);
endinterface

// ===== design/shp_in_reg.sv =====
// input register: holds one character item until the parse step takes it
// depends on shp_pkg and shp_in_if
`timescale 1ns / 1ps

module shp_in_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  shp_in_if.sink          in_i,
  input  logic            adv_i,
  output logic            vld_o,
  output shp_pkg::item_t  item_o
);

  logic           vld_d, vld_q;
  logic           acc;
  shp_pkg::item_t item_q;

  assign in_i.ready = !vld_q || adv_i;
  assign acc        = in_i.valid && in_i.ready;

  always_comb begin
    vld_d = vld_q;
    if (acc) begin
      vld_d = 1'b1;
    end else if (adv_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      item_q.char_code <= in_i.char_code;
      item_q.has_char  <= in_i.has_char;
      item_q.last      <= in_i.last;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

// ===== design/shp_core.sv =====
// parse state and the per-character step: prefix skip, nibble shift-add, overflow check
// depends on shp_pkg
`timescale 1ns / 1ps

module shp_core #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  shp_pkg::item_t    item_i,
  output shp_pkg::result_t  res_o
);

  logic [1:0]             pos_d, pos_q;
  logic                   fwz_d, fwz_q;
  logic [VALUE_WIDTH-1:0] acc_d, acc_q;
  logic                   dcn_d, dcn_q;
  shp_pkg::status_e       fail_d, fail_q;

  logic [1:0]             pos_n;
  logic                   fwz_n;
  logic [VALUE_WIDTH-1:0] acc_n;
  logic                   dcn_n;
  shp_pkg::status_e       fail_n;
  shp_pkg::hex_digit_t    dig;
  logic                   is_x;

  assign dig  = shp_pkg::hex_digit(item_i.char_code);
  assign is_x = (item_i.char_code == shp_pkg::CH_X_LO) ||
                (item_i.char_code == shp_pkg::CH_X_UP);

  // state after taking this item's character
  always_comb begin
    pos_n  = pos_q;
    fwz_n  = fwz_q;
    acc_n  = acc_q;
    dcn_n  = dcn_q;
    fail_n = fail_q;
    if (item_i.has_char) begin
      if (pos_q != shp_pkg::POS_LATER) begin
        pos_n = pos_q + 2'd1;
      end
      if (fail_q == shp_pkg::ST_OK) begin
        if (pos_q == shp_pkg::POS_SECOND && fwz_q && is_x) begin
          // 0x prefix: drop the leading zero
          acc_n = '0;
          dcn_n = 1'b0;
        end else begin
          if (pos_q == shp_pkg::POS_FIRST && item_i.char_code == shp_pkg::CH_0) begin
            fwz_n = 1'b1;
          end
          if (dig.bad) begin
            fail_n = shp_pkg::ST_BAD_CHAR;
          end else if (acc_q[VALUE_WIDTH-1 -: shp_pkg::NibbleW] != '0) begin
            fail_n = shp_pkg::ST_OVERFLOW;
          end else begin
            acc_n = {acc_q[VALUE_WIDTH-shp_pkg::NibbleW-1:0], dig.nibble};
            dcn_n = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    res_o.value  = '0;
    res_o.status = shp_pkg::ST_OK;
    if (fail_n != shp_pkg::ST_OK) begin
      res_o.status = fail_n;
    end else if (!dcn_n) begin
      res_o.status = shp_pkg::ST_NO_DIGITS;
    end else begin
      res_o.value = shp_pkg::ValueOutW'(acc_n);
    end
  end

  // closing item clears the parse for the next string
  always_comb begin
    pos_d  = pos_q;
    fwz_d  = fwz_q;
    acc_d  = acc_q;
    dcn_d  = dcn_q;
    fail_d = fail_q;
    if (adv_i) begin
      if (item_i.last) begin
        pos_d  = shp_pkg::POS_FIRST;
        fwz_d  = 1'b0;
        acc_d  = '0;
        dcn_d  = 1'b0;
        fail_d = shp_pkg::ST_OK;
      end else begin
        pos_d  = pos_n;
        fwz_d  = fwz_n;
        acc_d  = acc_n;
        dcn_d  = dcn_n;
        fail_d = fail_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= shp_pkg::POS_FIRST;
      fwz_q  <= 1'b0;
      acc_q  <= '0;
      dcn_q  <= 1'b0;
      fail_q <= shp_pkg::ST_OK;
    end else begin
      pos_q  <= pos_d;
      fwz_q  <= fwz_d;
      acc_q  <= acc_d;
      dcn_q  <= dcn_d;
      fail_q <= fail_d;
    end
  end

endmodule

// ===== design/shp_out_reg.sv =====
// result register: holds one result item until the sink takes it
// depends on shp_pkg and shp_out_if
`timescale 1ns / 1ps

module shp_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  shp_pkg::result_t  res_i,
  output logic              free_o,
  shp_out_if.source         out_o
);

  logic             vld_d, vld_q;
  shp_pkg::result_t res_q;

  assign free_o = !vld_q || out_o.ready;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (out_o.ready) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid  = vld_q;
  assign out_o.value  = res_q.value;
  assign out_o.status = res_q.status;

endmodule

// ===== design/strict_hex_quantity_parser_top.sv =====
// strict hex quantity parser: input register, parse step, result register
// depends on shp_pkg, shp_if, shp_in_reg, shp_core, shp_out_reg
//
//   channel | dir | payload                      | item
//   in_i    | in  | char_code, has_char, last    | one character (or empty mark)
//   out_o   | out | value, status                | one result per closing item
//
// one character item per cycle unless a closing item holds off the input; a closing
// item passes the input register and then the result register, which offers its result
// the step from input register to result register is one nibble shift-add and a
// four-bit overflow test on the top of the accumulator
// reset clears the parse state and both valid flags; no clearing pass
// a stalled result lets non-closing items pass; a closing item then waits in the
// input register and holds off the input until the result is taken
`timescale 1ns / 1ps

module strict_hex_quantity_parser_top #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  shp_in_if.sink      in_i,
  shp_out_if.source   out_o
);

  logic             in_vld;
  shp_pkg::item_t   item;
  shp_pkg::result_t res;
  logic             out_free;
  logic             adv;
  logic             load;

  // a closing item waits for room in the result register
  assign adv  = in_vld && (!item.last || out_free);
  assign load = adv && item.last;

  shp_in_reg u_in_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .adv_i  (adv),
    .vld_o  (in_vld),
    .item_o (item)
  );

  shp_core #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .item_i (item),
    .res_o  (res)
  );

  shp_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (load),
    .res_i  (res),
    .free_o (out_free),
    .out_o  (out_o)
  );

  // a failed parse never reports a value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status != shp_pkg::ST_OK |-> out_o.value == '0)
    else $error("nonzero value with failure status");

  // a new result only follows a closing item leaving the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(adv && item.last))
    else $error("result without closing item");

  // input back-pressure only while a closing item waits on a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> in_vld && item.last && out_o.valid && !out_o.ready)
    else $error("input stalled without cause");

endmodule

// ===== tb/tb_strict_hex_quantity_parser_top.sv =====
// testbench for the strict hex quantity parser: directed and random strings, checked
// against a parse predictor held in a small scoreboard class
// depends on shp_pkg, shp_if and strict_hex_quantity_parser_top
`timescale 1ns / 1ps

module tb_strict_hex_quantity_parser_top;

  localparam int unsigned VALUE_W   = 64;
  localparam int unsigned HEX_RADIX = 16;
  localparam int unsigned TAIL_CYC  = 8;
  localparam int unsigned DRAIN_CYC = 5000;
  localparam logic [shp_pkg::CharWidth-1:0] CH_SPACE = 8'h20;
  localparam logic [shp_pkg::CharWidth-1:0] CH_MINUS = 8'h2d;

  class quantity_checker;
    shp_pkg::result_t                expected_q[$];
    logic [1:0]                      char_pos;
    bit                              lead_zero;
    logic [shp_pkg::ValueOutW-1:0]   acc;
    bit                              have_digit;
    shp_pkg::status_e                fail_code;
    logic [shp_pkg::ValueOutW-1:0]   value_max;
    int unsigned                     failures;

    function new();
      value_max = {shp_pkg::ValueOutW{1'b1}} >> (shp_pkg::ValueOutW - VALUE_W);
      failures  = 0;
      clear();
    endfunction

    function void clear();
      char_pos   = shp_pkg::POS_FIRST;
      lead_zero  = 1'b0;
      acc        = '0;
      have_digit = 1'b0;
      fail_code  = shp_pkg::ST_OK;
    endfunction

    // 0..15 for a hex digit, HEX_RADIX for anything else
    function int unsigned nibble_of(logic [shp_pkg::CharWidth-1:0] c);
      if (c >= shp_pkg::CH_0 && c <= shp_pkg::CH_9) return int'(c - shp_pkg::CH_0);
      if (c >= shp_pkg::CH_A_LO && c <= shp_pkg::CH_F_LO)
        return int'(c - shp_pkg::CH_A_LO) + 10;
      if (c >= shp_pkg::CH_A_UP && c <= shp_pkg::CH_F_UP)
        return int'(c - shp_pkg::CH_A_UP) + 10;
      return HEX_RADIX;
    endfunction

    function void take_char(logic [shp_pkg::CharWidth-1:0] c);
      logic [1:0]  pos;
      int unsigned d;
      pos = char_pos;
      if (char_pos != shp_pkg::POS_LATER) char_pos++;
      if (fail_code != shp_pkg::ST_OK) return;
      // 0x / 0X prefix drops the leading zero again
      if (pos == shp_pkg::POS_SECOND && lead_zero &&
          (c == shp_pkg::CH_X_LO || c == shp_pkg::CH_X_UP)) begin
        acc        = '0;
        have_digit = 1'b0;
        return;
      end
      if (pos == shp_pkg::POS_FIRST && c == shp_pkg::CH_0) lead_zero = 1'b1;
      d = nibble_of(c);
      if (d >= HEX_RADIX) begin
        fail_code = shp_pkg::ST_BAD_CHAR;
        return;
      end
      if (acc > (value_max - shp_pkg::ValueOutW'(d)) / HEX_RADIX) begin
        fail_code = shp_pkg::ST_OVERFLOW;
        return;
      end
      acc        = ((acc << 4) + shp_pkg::ValueOutW'(d)) & value_max;
      have_digit = 1'b1;
    endfunction

    function void note_char_item(shp_pkg::item_t it);
      shp_pkg::result_t r;
      if (it.has_char) take_char(it.char_code);
      if (!it.last) return;
      r.value = '0;
      if (fail_code != shp_pkg::ST_OK) begin
        r.status = fail_code;
      end else if (!have_digit) begin
        r.status = shp_pkg::ST_NO_DIGITS;
      end else begin
        r.status = shp_pkg::ST_OK;
        r.value  = acc & value_max;
      end
      expected_q = {expected_q, r};
      clear();
    endfunction

    function void check_quantity(logic [shp_pkg::ValueOutW-1:0] value, logic [1:0] status);
      shp_pkg::result_t want;
      if (expected_q.size() == 0) begin
        failures++;
        $display("%0t: result with none pending, value %h status %0d", $time, value, status);
        return;
      end
      want = expected_q.pop_front();
      if (value !== want.value) begin
        failures++;
        $display("%0t: value mismatch, expected %h got %h", $time, want.value, value);
      end
      if (status !== want.status) begin
        failures++;
        $display("%0t: status mismatch, expected %0d got %0d", $time, want.status, status);
      end
    endfunction

    function int unsigned outstanding();
      return expected_q.size();
    endfunction

    function void check_drained();
      if (expected_q.size() != 0) begin
        failures++;
        $display("%0t: %0d results never arrived, oldest value %h status %0d", $time,
                 expected_q.size(), expected_q[0].value, expected_q[0].status);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  shp_in_if  in_if ();
  shp_out_if out_if ();

  strict_hex_quantity_parser_top #(
    .VALUE_WIDTH(VALUE_W)
  ) u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  quantity_checker                  sb;
  logic [shp_pkg::CharWidth-1:0]    text_q[$];
  int unsigned                      idle_pct;
  int unsigned                      stall_pct;
  int unsigned                      hold_left;
  int unsigned                      items_sent;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [shp_pkg::CharWidth-1:0] hex_char(int unsigned v);
    if (v < 10) return shp_pkg::CharWidth'(shp_pkg::CH_0 + v);
    return shp_pkg::CharWidth'(($urandom_range(0, 1) ? shp_pkg::CH_A_UP : shp_pkg::CH_A_LO)
                               + v - 10);
  endfunction

  task automatic send_item(input logic [shp_pkg::CharWidth-1:0] c, input bit has,
                           input bit fin);
    shp_pkg::item_t it;
    it.char_code = c;
    it.has_char  = has;
    it.last      = fin;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.char_code <= c;
    in_if.has_char  <= has;
    in_if.last      <= fin;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_char_item(it);
    if (has || fin) items_sent++;
  endtask

  // sends text_q as one string; an empty text_q is the empty string
  task automatic send_text(input bit close_empty, input int unsigned mid_empty_pct);
    int unsigned n;
    n = text_q.size();
    if (n == 0) begin
      send_item(shp_pkg::CharWidth'($urandom_range(0, 255)), 1'b0, 1'b1);
      return;
    end
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < mid_empty_pct)
        send_item(shp_pkg::CharWidth'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(text_q[i], 1'b1, (i == n - 1) && !close_empty);
    end
    if (close_empty) send_item(shp_pkg::CharWidth'($urandom_range(0, 255)), 1'b0, 1'b1);
    text_q.delete();
  endtask

  task automatic append_char(input logic [shp_pkg::CharWidth-1:0] c);
    text_q = {text_q, c};
  endtask

  task automatic load_text(input string s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) append_char(s[i]);
  endtask

  task automatic make_random_text();
    int unsigned kind;
    int unsigned ndig;
    int unsigned pos;
    logic [shp_pkg::CharWidth-1:0] bad;
    text_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 6) return;
    if (kind >= 90) begin
      repeat ($urandom_range(1, 6)) append_char(shp_pkg::CharWidth'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 2) == 0) begin
      append_char(shp_pkg::CH_0);
      append_char($urandom_range(0, 1) ? shp_pkg::CH_X_UP : shp_pkg::CH_X_LO);
    end
    if (kind < 55) begin
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 4)) append_char(shp_pkg::CH_0);
      ndig = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 16);
      repeat (ndig) append_char(hex_char($urandom_range(0, 15)));
    end else if (kind < 72) begin
      // right at the 64-bit limit or one digit past it
      ndig = $urandom_range(16, 17);
      append_char(hex_char($urandom_range(1, 15)));
      repeat (ndig - 1)
        append_char($urandom_range(0, 1) ? hex_char(15) : hex_char($urandom_range(0, 15)));
    end else begin
      // good digits with one spoiled character somewhere
      repeat ($urandom_range(1, 12)) append_char(hex_char($urandom_range(0, 15)));
      case ($urandom_range(0, 3))
        0:       bad = shp_pkg::CharWidth'($urandom_range(0, 255));
        1:       bad = $urandom_range(0, 1) ? shp_pkg::CH_X_UP : shp_pkg::CH_X_LO;
        2:       bad = CH_SPACE;
        default: bad = CH_MINUS;
      endcase
      pos = $urandom_range(0, text_q.size());
      text_q.insert(pos, bad);
    end
  endtask

  task automatic run_random(input int unsigned idle, input int unsigned stall,
                            input int unsigned count);
    int unsigned stop_at;
    idle_pct  = idle;
    stall_pct = stall;
    stop_at   = items_sent + count;
    while (items_sent < stop_at) begin
      make_random_text();
      send_text($urandom_range(0, 9) == 0, 4);
    end
  endtask

  // result side: random stalls, plus a long hold-off when asked for
  initial begin
    out_if.ready <= 1'b0;
    wait (rst_n);
    forever begin
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
      @(posedge clk);
      if (out_if.valid && out_if.ready) sb.check_quantity(out_if.value, out_if.status);
    end
  end

  initial begin
    int unsigned waited;
    sb              = new();
    idle_pct        = 0;
    stall_pct       = 0;
    hold_left       = 0;
    items_sent      = 0;
    rst_n           <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.char_code <= '0;
    in_if.has_char  <= 1'b0;
    in_if.last      <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty string, bare prefix, prefix of either case, misplaced x, sign
    load_text("");     send_text(1'b0, 0);
    load_text("0x");   send_text(1'b0, 0);
    load_text("0XaF"); send_text(1'b0, 0);
    load_text("x1");   send_text(1'b0, 0);
    load_text("-5");   send_text(1'b0, 0);
    // closed by an item without character
    load_text("7");    send_text(1'b1, 0);
    // characterless item in the middle
    send_item("1", 1'b1, 1'b0);
    send_item(8'hff, 1'b0, 1'b0);
    send_item("2", 1'b1, 1'b1);
    load_text("0");    send_text(1'b0, 0);
    // x at the third position, and the first of two failures
    load_text("00x");  send_text(1'b0, 0);
    load_text("9Gx");  send_text(1'b0, 0);

    run_random(0, 0, 150);
    run_random(84, 0, 150);
    run_random(0, 84, 150);
    // results held back for a long stretch while characters keep coming
    hold_left = 150;
    run_random(0, 0, 60);
    run_random(22, 22, 170);
    in_if.valid <= 1'b0;

    waited = 0;
    while (sb.outstanding() != 0 && waited < DRAIN_CYC) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYC) @(posedge clk);
    sb.check_drained();
    if (sb.failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/shp_pkg.sv
design/shp_if.sv
design/shp_in_reg.sv
design/shp_core.sv
design/shp_out_reg.sv
design/strict_hex_quantity_parser_top.sv
tb/tb_strict_hex_quantity_parser_top.sv
